// ===== rtl/segment_line_fit_from_moments_top_defines.svh =====
// Assertion macros shared by the segment line fit RTL.
`ifndef SEGMENT_LINE_FIT_FROM_MOMENTS_TOP_DEFINES_SVH
`define SEGMENT_LINE_FIT_FROM_MOMENTS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SLF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slf_pkg.sv =====
// Package with constants, stage map and pipeline types of the segment line fit.
`default_nettype none
package slf_pkg;

  // Ring storage.
  localparam int RING_DEPTH = 1024;
  localparam int RAM_AW     = $clog2(RING_DEPTH);
  localparam int ENTRY_W    = 384;

  // Moment slots inside one ring entry.
  localparam int M_W  = 0;
  localparam int M_X  = 1;
  localparam int M_Y  = 2;
  localparam int M_XX = 3;
  localparam int M_XY = 4;
  localparam int M_YY = 5;

  // Unit latencies in cycles.
  localparam int DIV_LAT  = 96;
  localparam int SQRT_LAT = 64;
  localparam int MUL_LAT  = 2;

  // Stage map: index of the pipeline register that holds each result.
  localparam int ST_M    = 1;
  localparam int ST_DQ   = ST_M + DIV_LAT;
  localparam int ST_E    = ST_DQ + 1;
  localparam int ST_PQ   = ST_E + MUL_LAT;
  localparam int ST_C    = ST_PQ + 2;
  localparam int ST_D    = ST_C + 1;
  localparam int ST_SQ   = ST_D + MUL_LAT;
  localparam int ST_S    = ST_SQ + 1;
  localparam int ST_DIST = ST_S + SQRT_LAT;
  localparam int ST_AB   = ST_DIST + 1;
  localparam int ST_QQ   = ST_AB + MUL_LAT;
  localparam int ST_CH   = ST_QQ + 1;
  localparam int ST_NM   = ST_CH + 1;
  localparam int ST_SH   = ST_NM + 1;
  localparam int ST_MP   = ST_SH + 1;
  localparam int ST_L    = ST_MP + 1;
  localparam int ST_LEN  = ST_L + SQRT_LAT;
  localparam int ST_NQ   = ST_LEN + DIV_LAT;
  localparam int ST_OUT  = ST_NQ + 1;
  localparam int NST     = ST_OUT + 1;

  typedef logic [5:0][63:0] moments_t;

  // Data that travels down the pipeline with each query.
  typedef struct packed {
    logic             bad;
    logic [9:0]       f;
    logic [9:0]       l;
    logic [10:0]      n;
    logic [10:0]      count;
    moments_t         m;
    logic [47:0]      ex;
    logic [47:0]      ey;
    logic [2:0][97:0] t;
    logic [2:0][97:0] diff;
    logic [2:0][63:0] cov;
    logic [63:0]      d;
    logic [63:0]      e;
    logic [63:0]      dm;
    logic [63:0]      em;
    logic [127:0]     s;
    logic [62:0]      eig;
    logic [3:0][63:0] ab;
    logic [3:0][63:0] abm;
    logic [62:0]      tot;
    logic [47:0]      mse;
    logic [127:0]     q1;
    logic [127:0]     q2;
    logic             na;
    logic             nb;
    logic             qnz;
    logic [63:0]      ua;
    logic [63:0]      ub;
    logic [61:0]      sa;
    logic [61:0]      sb;
    logic [62:0]      mp;
    logic [31:0]      nx;
    logic [31:0]      ny;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/slf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module slf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/slf_div.sv =====
// Pipelined restoring divider, 96-bit numerator by 64-bit divisor, one bit per stage.
`default_nettype none
module slf_div
  import slf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [95:0] num,
  input  wire logic [63:0] den,
  output logic      [95:0] quo
);

  // Numerator bits shift out at the top while quotient bits shift in below.
  logic [95:0] nq_r  [DIV_LAT];
  logic [63:0] rem_r [DIV_LAT];
  logic [63:0] den_r [DIV_LAT];
  logic [95:0] nq_nxt  [DIV_LAT];
  logic [63:0] rem_nxt [DIV_LAT];

  always_comb begin
    logic [95:0] nq;
    logic [63:0] rm;
    logic [63:0] dv;
    logic [64:0] tr;
    for (int k = 0; k < DIV_LAT; k++) begin
      nq = (k == 0) ? num : nq_r[(k == 0) ? 0 : k - 1];
      rm = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k - 1];
      dv = (k == 0) ? den : den_r[(k == 0) ? 0 : k - 1];
      tr = {rm, nq[95]};
      if (tr >= {1'b0, dv}) begin
        rem_nxt[k] = 64'(tr - {1'b0, dv});
        nq_nxt[k]  = {nq[94:0], 1'b1};
      end else begin
        rem_nxt[k] = tr[63:0];
        nq_nxt[k]  = {nq[94:0], 1'b0};
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    den_r[0] <= den;
    for (int k = 0; k < DIV_LAT; k++) begin
      nq_r[k]  <= nq_nxt[k];
      rem_r[k] <= rem_nxt[k];
      if (k > 0) begin
        den_r[k] <= den_r[k - 1];
      end
    end
  end

  assign quo = nq_r[DIV_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/slf_sqrt.sv =====
// Pipelined integer square root of a 128-bit value, one root bit per stage.
`default_nettype none
module slf_sqrt
  import slf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic [127:0] val,
  output logic      [63:0]  root
);

  logic [127:0] v_r    [SQRT_LAT];
  logic [65:0]  rem_r  [SQRT_LAT];
  logic [63:0]  root_r [SQRT_LAT];
  logic [65:0]  rem_nxt  [SQRT_LAT];
  logic [63:0]  root_nxt [SQRT_LAT];

  // Each stage brings down two radicand bits and tries one more root bit.
  always_comb begin
    logic [127:0] vs;
    logic [65:0]  rm;
    logic [63:0]  rt;
    logic [67:0]  tr;
    logic [67:0]  trial;
    for (int k = 0; k < SQRT_LAT; k++) begin
      vs = (k == 0) ? val : v_r[(k == 0) ? 0 : k - 1];
      rm = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k - 1];
      rt = (k == 0) ? '0  : root_r[(k == 0) ? 0 : k - 1];
      tr    = {rm, vs[127:126]};
      trial = {2'b00, rt, 2'b01};
      if (tr >= trial) begin
        rem_nxt[k]  = 66'(tr - trial);
        root_nxt[k] = {rt[62:0], 1'b1};
      end else begin
        rem_nxt[k]  = tr[65:0];
        root_nxt[k] = {rt[62:0], 1'b0};
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    v_r[0] <= {val[125:0], 2'b00};
    for (int k = 0; k < SQRT_LAT; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      if (k > 0) begin
        v_r[k] <= {v_r[k - 1][125:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/slf_mul.sv =====
// Two-stage 64 by 64 unsigned multiplier built from 32 by 32 partial products.
`default_nettype none
module slf_mul (
  input  wire logic         clk,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] p
);

  logic [63:0] p00_r, p01_r, p10_r, p11_r;

  // Partial products, then their aligned sum.
  always_ff @(posedge clk) begin
    p00_r <= a[31:0]  * b[31:0];
    p01_r <= a[31:0]  * b[63:32];
    p10_r <= a[63:32] * b[31:0];
    p11_r <= a[63:32] * b[63:32];
    p     <= {p11_r, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0};
  end

endmodule
`default_nettype wire

// ===== rtl/segment_line_fit_from_moments_top.sv =====
// Top level of the segment line fit: moment ring, segment sums and the fit pipeline.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | start / busy       | in_mode, in_load_addr, in_sum_*, in_seg_*, ...
//  result   | out_valid (strobe) | out_point_count, out_centroid_*, out_normal_*, ...
//
// A load is written to the ring at its accept edge and gives no result.
// A query is accepted in every cycle; its result reaches the ports through the
// chain of two 96-stage dividers and two 64-stage square roots. busy is never
// raised, so no transaction is held off. Reset clears the stage valid bits only;
// the ring is not cleared.
`default_nettype none
`include "segment_line_fit_from_moments_top_defines.svh"
module segment_line_fit_from_moments_top
  import slf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_mode,
  input  wire logic [9:0]         in_load_addr,
  input  wire logic [62:0]        in_sum_w,
  input  wire logic signed [63:0] in_sum_x,
  input  wire logic signed [63:0] in_sum_y,
  input  wire logic signed [63:0] in_sum_xx,
  input  wire logic signed [63:0] in_sum_xy,
  input  wire logic signed [63:0] in_sum_yy,
  input  wire logic [9:0]         in_seg_first,
  input  wire logic [9:0]         in_seg_last,
  input  wire logic [10:0]        in_ring_length,
  output logic                    out_valid,
  output logic [10:0]             out_point_count,
  output logic signed [47:0]      out_centroid_x,
  output logic signed [47:0]      out_centroid_y,
  output logic signed [31:0]      out_normal_x,
  output logic signed [31:0]      out_normal_y,
  output logic [47:0]             out_fit_mse,
  output logic [62:0]             out_fit_total_error,
  output logic                    out_status
);

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? 64'(0 - v) : v;
  endfunction

  // Saturate a signed centroid quotient to 48 bits.
  function automatic logic [47:0] sat48(input logic neg, input logic [95:0] q);
    if (!neg) begin
      sat48 = (q > 96'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q[47:0];
    end else begin
      sat48 = (q > 96'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'(0 - q[47:0]);
    end
  endfunction

  logic      acc;
  logic      we;
  logic [ENTRY_W-1:0] rd_l_w, rd_f_w, rd_n_w;
  moments_t  rd_l, rd_f, rd_n;
  logic [NST-1:0] vld_r;
  side_t     side_r   [NST];
  side_t     side_nxt [NST-1];

  logic [95:0]  q_ex, q_ey, q_nx, q_ny;
  logic [95:0]  q_c [3];
  logic [127:0] p_c [3];
  logic [127:0] p_d, p_e;
  logic [127:0] p_ab [4];
  logic [63:0]  sq_dist, sq_len;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign we   = acc && !in_mode && (32'(in_load_addr) < RING_DEPTH);

  // Three ring copies give the three reads a wrapping segment needs.
  slf_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ram_l (
    .clk, .we, .waddr(RAM_AW'(in_load_addr)),
    .wdata({in_sum_yy, in_sum_xy, in_sum_xx, in_sum_y, in_sum_x, 1'b0, in_sum_w}),
    .raddr(RAM_AW'(in_seg_last)), .rdata(rd_l_w));
  slf_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ram_f (
    .clk, .we, .waddr(RAM_AW'(in_load_addr)),
    .wdata({in_sum_yy, in_sum_xy, in_sum_xx, in_sum_y, in_sum_x, 1'b0, in_sum_w}),
    .raddr(RAM_AW'(in_seg_first - 10'd1)), .rdata(rd_f_w));
  slf_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_DEPTH)) u_ram_n (
    .clk, .we, .waddr(RAM_AW'(in_load_addr)),
    .wdata({in_sum_yy, in_sum_xy, in_sum_xx, in_sum_y, in_sum_x, 1'b0, in_sum_w}),
    .raddr(RAM_AW'(in_ring_length - 11'd1)), .rdata(rd_n_w));

  assign rd_l = rd_l_w;
  assign rd_f = rd_f_w;
  assign rd_n = rd_n_w;

  // Centroid and second-moment divisions, all by the segment weight.
  slf_div u_div_ex (.clk, .num({16'b0, mag64(side_r[ST_M].m[M_X]), 16'b0}),
                    .den(side_r[ST_M].m[M_W]), .quo(q_ex));
  slf_div u_div_ey (.clk, .num({16'b0, mag64(side_r[ST_M].m[M_Y]), 16'b0}),
                    .den(side_r[ST_M].m[M_W]), .quo(q_ey));

  for (genvar j = 0; j < 3; j++) begin : g_cov
    slf_div u_div_c (.clk, .num({mag64(side_r[ST_M].m[M_XX + j]), 32'b0}),
                     .den(side_r[ST_M].m[M_W]), .quo(q_c[j]));
    slf_mul u_mul_c (.clk,
      .a(mag64({{16{(j == 2) ? side_r[ST_E].ey[47] : side_r[ST_E].ex[47]}},
                (j == 2) ? side_r[ST_E].ey : side_r[ST_E].ex})),
      .b(mag64({{16{(j == 0) ? side_r[ST_E].ex[47] : side_r[ST_E].ey[47]}},
                (j == 0) ? side_r[ST_E].ex : side_r[ST_E].ey})),
      .p(p_c[j]));
  end

  // Eigenvalue discriminant.
  slf_mul u_mul_d (.clk, .a(side_r[ST_D].dm), .b(side_r[ST_D].dm), .p(p_d));
  slf_mul u_mul_e (.clk, .a(side_r[ST_D].em), .b(side_r[ST_D].em), .p(p_e));
  slf_sqrt u_sqrt_dist (.clk, .val(side_r[ST_S].s), .root(sq_dist));

  // Squared lengths of the two normal candidates.
  for (genvar j = 0; j < 4; j++) begin : g_ab
    slf_mul u_mul_ab (.clk, .a(side_r[ST_AB].abm[j]), .b(side_r[ST_AB].abm[j]),
                      .p(p_ab[j]));
  end

  // Normal length and unit components.
  slf_sqrt u_sqrt_len (.clk, .val({33'b0, side_r[ST_L].mp, 32'b0}), .root(sq_len));
  slf_div u_div_nx (.clk, .num({19'b0, side_r[ST_LEN].ua[30:0], 46'b0}),
                    .den(sq_len), .quo(q_nx));
  slf_div u_div_ny (.clk, .num({19'b0, side_r[ST_LEN].ub[30:0], 46'b0}),
                    .den(sq_len), .quo(q_ny));

  // Per-stage updates of the travelling query data.
  always_comb begin
    logic [63:0]  pv;
    logic [97:0]  pr;
    logic [81:0]  cs;
    logic [73:0]  tp;
    logic [63:0]  ca;
    logic [63:0]  cb;
    logic [63:0]  mx;
    logic [5:0]   pos;
    logic [63:0]  en;
    logic [127:0] qm;
    logic [31:0]  nv;
    pv = '0; pr = '0; cs = '0; tp = '0; ca = '0; cb = '0;
    mx = '0; pos = '0; en = '0; qm = '0; nv = '0;
    for (int k = 0; k < NST - 1; k++) begin
      side_nxt[k] = side_r[k];
    end

    // Segment sums and point count from the ring reads.
    for (int k = 0; k < 6; k++) begin
      pv = (side_r[0].f != 10'd0) ? rd_f[k] : '0;
      if (side_r[0].f < side_r[0].l) begin
        side_nxt[0].m[k] = rd_l[k] - pv;
      end else begin
        side_nxt[0].m[k] = rd_n[k] - rd_f[k] + rd_l[k];
      end
    end
    if (side_r[0].f < side_r[0].l) begin
      side_nxt[0].count = {1'b0, side_r[0].l} - {1'b0, side_r[0].f} + 11'd1;
    end else begin
      side_nxt[0].count = side_r[0].n - {1'b0, side_r[0].f} + {1'b0, side_r[0].l} + 11'd1;
    end
    side_nxt[0].bad = side_r[0].bad || (side_nxt[0].m[M_W] == 64'd0) ||
                      side_nxt[0].m[M_W][63];

    // Signed quotients.
    side_nxt[ST_DQ].ex = sat48(side_r[ST_DQ].m[M_X][63], q_ex);
    side_nxt[ST_DQ].ey = sat48(side_r[ST_DQ].m[M_Y][63], q_ey);
    for (int j = 0; j < 3; j++) begin
      side_nxt[ST_DQ].t[j] = side_r[ST_DQ].m[M_XX + j][63] ?
                             98'(0 - {2'b0, q_c[j]}) : {2'b0, q_c[j]};
    end

    // Second moment minus the product of means.
    for (int j = 0; j < 3; j++) begin
      pr = p_c[j][97:0];
      if ((j == 1) && (side_r[ST_PQ].ex[47] != side_r[ST_PQ].ey[47])) begin
        pr = 98'(0 - pr);
      end
      side_nxt[ST_PQ].diff[j] = side_r[ST_PQ].t[j] - pr;
    end

    // Back to Q.16 and saturate to 61 bits.
    for (int j = 0; j < 3; j++) begin
      cs = 82'($signed(side_r[ST_PQ + 1].diff[j]) >>> 16);
      if (cs[81] && !(&cs[81:60])) begin
        side_nxt[ST_PQ + 1].cov[j] = {4'hF, 60'h0};
      end else if (!cs[81] && (|cs[80:60])) begin
        side_nxt[ST_PQ + 1].cov[j] = {4'h0, {60{1'b1}}};
      end else begin
        side_nxt[ST_PQ + 1].cov[j] = {{3{cs[60]}}, cs[60:0]};
      end
    end

    // Covariance differences.
    side_nxt[ST_C].d  = side_r[ST_C].cov[0] - side_r[ST_C].cov[2];
    side_nxt[ST_C].e  = {side_r[ST_C].cov[1][62:0], 1'b0};
    side_nxt[ST_C].dm = mag64(side_nxt[ST_C].d);
    side_nxt[ST_C].em = mag64(side_nxt[ST_C].e);

    side_nxt[ST_SQ].s = p_d + p_e;

    // Eigenvalue and the two normal candidates.
    en = side_r[ST_DIST].cov[0] + side_r[ST_DIST].cov[2] - sq_dist;
    side_nxt[ST_DIST].eig = ($signed(en) > 64'sd0) ? en[63:1] : '0;
    side_nxt[ST_DIST].ab[0] = side_r[ST_DIST].d - sq_dist;
    side_nxt[ST_DIST].ab[1] = side_r[ST_DIST].e;
    side_nxt[ST_DIST].ab[2] = side_r[ST_DIST].e;
    side_nxt[ST_DIST].ab[3] = 64'(0 - side_r[ST_DIST].d - sq_dist);
    for (int j = 0; j < 4; j++) begin
      side_nxt[ST_DIST].abm[j] = mag64(side_nxt[ST_DIST].ab[j]);
    end

    // Total error and saturated mse.
    tp = {63'b0, side_r[ST_AB].count} * {11'b0, side_r[ST_AB].eig};
    side_nxt[ST_AB].tot = (|tp[73:63]) ? {63{1'b1}} : tp[62:0];
    side_nxt[ST_AB].mse = (|side_r[ST_AB].eig[62:48]) ? {48{1'b1}} :
                          side_r[ST_AB].eig[47:0];

    side_nxt[ST_QQ].q1 = p_ab[0] + p_ab[1];
    side_nxt[ST_QQ].q2 = p_ab[2] + p_ab[3];

    // Pick the longer candidate.
    if (side_r[ST_CH].q1 > side_r[ST_CH].q2) begin
      ca = side_r[ST_CH].ab[0]; cb = side_r[ST_CH].ab[1]; qm = side_r[ST_CH].q1;
    end else begin
      ca = side_r[ST_CH].ab[2]; cb = side_r[ST_CH].ab[3]; qm = side_r[ST_CH].q2;
    end
    side_nxt[ST_CH].na  = ca[63];
    side_nxt[ST_CH].nb  = cb[63];
    side_nxt[ST_CH].ua  = mag64(ca);
    side_nxt[ST_CH].ub  = mag64(cb);
    side_nxt[ST_CH].qnz = (qm != 128'd0);

    // Normalize so the larger magnitude lies in [2^30, 2^31).
    mx = (side_r[ST_NM].ua > side_r[ST_NM].ub) ? side_r[ST_NM].ua : side_r[ST_NM].ub;
    for (int i = 0; i < 64; i++) begin
      if (mx[i]) begin
        pos = 6'(i);
      end
    end
    if (pos > 6'd30) begin
      side_nxt[ST_NM].ua = side_r[ST_NM].ua >> (pos - 6'd30);
      side_nxt[ST_NM].ub = side_r[ST_NM].ub >> (pos - 6'd30);
    end else begin
      side_nxt[ST_NM].ua = side_r[ST_NM].ua << (6'd30 - pos);
      side_nxt[ST_NM].ub = side_r[ST_NM].ub << (6'd30 - pos);
    end

    side_nxt[ST_SH].sa = side_r[ST_SH].ua[30:0] * side_r[ST_SH].ua[30:0];
    side_nxt[ST_SH].sb = side_r[ST_SH].ub[30:0] * side_r[ST_SH].ub[30:0];
    side_nxt[ST_MP].mp = {1'b0, side_r[ST_MP].sa} + {1'b0, side_r[ST_MP].sb};

    // Unit components, capped and signed; failed queries read as zero.
    nv = (q_nx > 96'h4000_0000) ? 32'h4000_0000 : q_nx[31:0];
    side_nxt[ST_NQ].nx = !side_r[ST_NQ].qnz ? '0 : (side_r[ST_NQ].na ? 32'(0 - nv) : nv);
    nv = (q_ny > 96'h4000_0000) ? 32'h4000_0000 : q_ny[31:0];
    side_nxt[ST_NQ].ny = !side_r[ST_NQ].qnz ? '0 : (side_r[ST_NQ].nb ? 32'(0 - nv) : nv);
    if (side_r[ST_NQ].bad) begin
      side_nxt[ST_NQ].count = '0;
      side_nxt[ST_NQ].ex    = '0;
      side_nxt[ST_NQ].ey    = '0;
      side_nxt[ST_NQ].nx    = '0;
      side_nxt[ST_NQ].ny    = '0;
      side_nxt[ST_NQ].mse   = '0;
      side_nxt[ST_NQ].tot   = '0;
    end
  end

  // Pipeline registers; a query enters with its range check.
  always_ff @(posedge clk) begin
    side_r[0].f   <= in_seg_first;
    side_r[0].l   <= in_seg_last;
    side_r[0].n   <= in_ring_length;
    side_r[0].bad <= (in_ring_length == 11'd0) || (32'(in_ring_length) > RING_DEPTH) ||
                     ({1'b0, in_seg_first} >= in_ring_length) ||
                     ({1'b0, in_seg_last} >= in_ring_length) ||
                     (in_seg_first == in_seg_last);
    for (int k = 0; k < NST - 1; k++) begin
      side_r[k + 1] <= side_nxt[k];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], acc && in_mode};
    end
  end

  assign out_valid           = vld_r[ST_OUT];
  assign out_point_count     = side_r[ST_OUT].count;
  assign out_centroid_x      = side_r[ST_OUT].ex;
  assign out_centroid_y      = side_r[ST_OUT].ey;
  assign out_normal_x        = side_r[ST_OUT].nx;
  assign out_normal_y        = side_r[ST_OUT].ny;
  assign out_fit_mse         = side_r[ST_OUT].mse;
  assign out_fit_total_error = side_r[ST_OUT].tot;
  assign out_status          = side_r[ST_OUT].bad;

  // Checks on the pipeline.
  `SLF_ASSERT_NXT(a_query_enters, start && !busy && in_mode, vld_r[0], "query did not enter")
  `SLF_ASSERT_IMP(a_fail_zero, out_valid && out_status, (out_point_count == 11'd0) && (out_fit_mse == 48'd0) && (out_normal_x == 32'sd0), "failed fit not zeroed")
  `SLF_ASSERT_IMP(a_fit_count, out_valid && !out_status, out_point_count >= 11'd2, "fit with fewer than two points")
  `SLF_ASSERT_IMP(a_total_ge_mse, out_valid && !out_status, 63'(out_fit_mse) <= out_fit_total_error, "total error below mse")

endmodule
`default_nettype wire
